>>> sv/utf8_stream_decoder_macros.svh
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// same-cycle implication, masked during reset
`define U8SD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder check failed");

// next-cycle implication, masked during reset
`define U8SD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder check failed");

`endif

>>> sv/utf8sd_pkg.sv
// shared types and constants for the utf8 stream decoder
package utf8sd_pkg;

    localparam logic [20:0] REPL_CP = 21'h00FFFD;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [2:0]  rcount;
        logic        has_cp;
        logic [20:0] cp;
        logic [2:0]  used;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> sv/utf8sd_front.sv
// front end: sequence tracking and per-byte run classification
module utf8sd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte_value,
    input  logic               i_final_byte,
    output logic               o_push,
    output utf8sd_pkg::t_cmd   o_cmd
);

    logic [2:0]  r_exp_len, n_exp_len;
    logic [1:0]  r_cont_cnt, n_cont_cnt;
    logic [20:0] r_partial, n_partial;

    logic        is_cont;
    logic [2:0]  taken;
    logic [20:0] shifted;
    logic [2:0]  need;
    logic [20:0] lead_bits;
    utf8sd_pkg::t_cmd cmd;

    always_comb begin
        is_cont = (i_byte_value[7:6] == 2'b10);
        taken = {1'b0, r_cont_cnt} + 3'd1;
        shifted = {r_partial[14:0], i_byte_value[5:0]};
        need = 3'd0;
        lead_bits = 21'd0;
        if (i_byte_value inside {[8'hC0:8'hDF]}) begin
            need = 3'd2;
            lead_bits = {16'd0, i_byte_value[4:0]};
        end else if (i_byte_value inside {[8'hE0:8'hEF]}) begin
            need = 3'd3;
            lead_bits = {17'd0, i_byte_value[3:0]};
        end else if (i_byte_value inside {[8'hF0:8'hF7]}) begin
            need = 3'd4;
            lead_bits = {18'd0, i_byte_value[2:0]};
        end

        cmd = '0;
        n_exp_len = r_exp_len;
        n_cont_cnt = r_cont_cnt;
        n_partial = r_partial;

        if (r_exp_len != 3'd0 && is_cont) begin
            if (taken + 3'd1 >= r_exp_len) begin
                cmd.has_cp = 1'b1;
                cmd.cp = shifted;
                cmd.used = r_exp_len;
                n_exp_len = 3'd0;
                n_cont_cnt = 2'd0;
                n_partial = 21'd0;
            end else if (i_final_byte) begin
                cmd.rcount = taken + 3'd1;
                n_exp_len = 3'd0;
                n_cont_cnt = 2'd0;
                n_partial = 21'd0;
            end else begin
                n_cont_cnt = taken[1:0];
                n_partial = shifted;
            end
        end else begin
            if (r_exp_len != 3'd0) begin
                cmd.rcount = taken;
            end
            n_exp_len = 3'd0;
            n_cont_cnt = 2'd0;
            n_partial = 21'd0;
            if (!i_byte_value[7]) begin
                cmd.has_cp = 1'b1;
                cmd.cp = {13'd0, i_byte_value};
                cmd.used = 3'd1;
            end else if (need == 3'd0 || i_final_byte) begin
                cmd.rcount = cmd.rcount + 3'd1;
            end else begin
                n_exp_len = need;
                n_partial = lead_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= 3'd0;
            r_cont_cnt <= 2'd0;
            r_partial <= 21'd0;
        end else if (i_accept) begin
            r_exp_len <= n_exp_len;
            r_cont_cnt <= n_cont_cnt;
            r_partial <= n_partial;
        end
    end

    assign o_push = i_accept && (cmd.rcount != 3'd0 || cmd.has_cp);
    assign o_cmd = cmd;

endmodule

>>> sv/utf8sd_queue.sv
// short run-command queue between front and back
module utf8sd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  utf8sd_pkg::t_cmd    i_cmd,
    input  logic                i_pop,
    output utf8sd_pkg::t_cmd    o_head,
    output utf8sd_pkg::t_qstat  o_stat
);

    utf8sd_pkg::t_cmd r_mem [utf8sd_pkg::Q_DEPTH];
    logic [utf8sd_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [utf8sd_pkg::Q_AW:0]   r_count;

    logic do_push, do_pop;

    assign o_stat.full = (r_count == (utf8sd_pkg::Q_AW+1)'(utf8sd_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop = i_pop && !o_stat.empty;
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + (utf8sd_pkg::Q_AW)'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + (utf8sd_pkg::Q_AW)'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (utf8sd_pkg::Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (utf8sd_pkg::Q_AW+1)'(1);
            end
        end
    end

endmodule

>>> sv/utf8sd_back.sv
// back end: expands run commands into result words with an output register
module utf8sd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utf8sd_pkg::t_cmd    i_head,
    input  utf8sd_pkg::t_qstat  i_qstat,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [20:0]         o_code_point,
    output logic                o_is_replacement,
    output logic [2:0]          o_bytes_used,
    output logic                o_last_of_run
);

    logic [1:0]  r_sent;
    logic        r_valid;
    logic [20:0] r_cp;
    logic        r_repl;
    logic [2:0]  r_used;
    logic        r_last;

    logic advance, fire, is_repl, last;

    always_comb begin
        advance = !r_valid || !i_stall;
        fire = advance && !i_qstat.empty;
        is_repl = ({1'b0, r_sent} < i_head.rcount);
        if (is_repl) begin
            last = ({1'b0, r_sent} + 3'd1 == i_head.rcount) && !i_head.has_cp;
        end else begin
            last = 1'b1;
        end
    end

    assign o_pop = fire && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent <= 2'd0;
        end else if (advance) begin
            r_valid <= fire;
            if (fire) begin
                r_sent <= last ? 2'd0 : r_sent + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cp <= is_repl ? utf8sd_pkg::REPL_CP : i_head.cp;
            r_repl <= is_repl;
            r_used <= is_repl ? 3'd1 : i_head.used;
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_code_point = r_cp;
    assign o_is_replacement = r_repl;
    assign o_bytes_used = r_used;
    assign o_last_of_run = r_last;

endmodule

>>> sv/utf8_stream_decoder.sv
// utf8 stream decoder top level
// a result's command is queued first, then its word is held in the output register
// throughput: one byte per cycle unless stalled; each error run result is one word
// a four-entry command queue absorbs runs; input stalls only when it is full
// reset: synchronous active low, clears sequence state, queue and output valid
// no clearing pass after reset; the block takes bytes on the first cycle out of reset
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic        o_is_replacement,
    output logic [2:0]  o_bytes_used,
    output logic        o_last_of_run
);

    utf8sd_pkg::t_cmd   push_cmd;
    utf8sd_pkg::t_cmd   head_cmd;
    utf8sd_pkg::t_qstat qstat;
    logic accept, push, pop;

    assign o_stall = qstat.full;
    assign accept = i_valid && !qstat.full;

    utf8sd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_value (i_byte_value),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    utf8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (qstat)
    );

    utf8sd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_cmd),
        .i_qstat          (qstat),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement),
        .o_bytes_used     (o_bytes_used),
        .o_last_of_run    (o_last_of_run)
    );

    `U8SD_ASSERT_NOW(a_repl_word, o_valid && o_is_replacement, o_code_point == utf8sd_pkg::REPL_CP && o_bytes_used == 3'd1)
    `U8SD_ASSERT_NOW(a_decoded_ends_run, o_valid && !o_is_replacement, o_last_of_run)
    `U8SD_ASSERT_NOW(a_single_byte_ascii, o_valid && !o_is_replacement && o_bytes_used == 3'd1, o_code_point[20:7] == 14'd0)
    `U8SD_ASSERT_NEXT(a_queue_fed_output, !qstat.empty && !o_valid, o_valid)

endmodule
